@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IRN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define IRN_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `IRN_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define IRN_ASSERT(lbl, clk, rst_n, prop)
`define IRN_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ rtl/irn_pkg.sv @@
package irn_pkg;

  localparam int unsigned COORD_W     = 7;
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned DIM_W       = 8;
  localparam int unsigned TERM_W      = 16;
  localparam int unsigned FRAC_W      = 14;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HALF_Q      = 1 << (FRAC_W - 1);
  localparam int unsigned TRUNC_BIAS  = (1 << FRAC_W) - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_COS_TERM     = 2'd2,
    REG_SIN_TERM     = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_FETCH = 1'b1
  } mode_e;

  typedef struct packed {
    logic fetch;
    logic wr_en;
    logic in_img;
  } op_ctrl_t;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [TERM_W-1:0] cos_term;
    logic [TERM_W-1:0] sin_term;
  } rot_cfg_t;

endpackage

@@ rtl/irn_in_if.sv @@
interface irn_in_if;
  import irn_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic [PIXEL_W-1:0] pixel_in;

  modport source (output valid, mode, col, row, pixel_in, input ready);
  modport sink (input valid, mode, col, row, pixel_in, output ready);
endinterface

@@ rtl/irn_out_if.sv @@
interface irn_out_if;
  import irn_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_out;
  logic               inside_res;

  modport source (output valid, pixel_out, inside_res, input ready);
  modport sink (input valid, pixel_out, inside_res, output ready);
endinterface

@@ rtl/irn_front.sv @@
module irn_front #(
  parameter int unsigned MAX_DIM = 128,
  parameter int unsigned ADDR_W  = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  irn_in_if.sink                      in_if,
  input  irn_pkg::rot_cfg_t           cfg_i,
  input  logic [irn_pkg::QCNT_W-1:0]  q_count_i,
  output logic                        push_o,
  output irn_pkg::op_ctrl_t           push_ctrl_o,
  output logic [ADDR_W-1:0]           push_addr_o,
  output logic [irn_pkg::PIXEL_W-1:0] push_pixel_o
);
  import irn_pkg::*;

  localparam int unsigned LIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned EW    = (LIM_W > DIM_W) ? LIM_W : DIM_W;
  localparam int unsigned DW    = EW + 1;
  localparam int unsigned PW    = TERM_W + DW;
  localparam int unsigned SW    = PW + 2;
  localparam int unsigned QW    = SW - FRAC_W;

  logic [EW-1:0] dim_max, w_eff, h_eff, ox, oy, col_w, row_w;
  logic [QCNT_W:0] pending;
  logic accept, load_ok;
  logic [ADDR_W-1:0] load_addr;

  logic                 s1_valid_q, s1_fetch_q, s1_wr_en_q;
  logic [ADDR_W-1:0]    s1_addr_q;
  logic [PIXEL_W-1:0]   s1_pixel_q;
  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s1_dx_d, s1_dy_d;

  logic                 s2_valid_q, s2_fetch_q, s2_wr_en_q;
  logic [ADDR_W-1:0]    s2_addr_q;
  logic [PIXEL_W-1:0]   s2_pixel_q;
  logic signed [PW-1:0] cdx_d, sdy_d, sdx_d, cdy_d;
  logic signed [PW-1:0] s2_cdx_q, s2_sdy_q, s2_sdx_q, s2_cdy_q;

  logic                 s3_valid_q, s3_fetch_q, s3_wr_en_q;
  logic [ADDR_W-1:0]    s3_addr_q;
  logic [PIXEL_W-1:0]   s3_pixel_q;
  logic signed [SW-1:0] tx_d, ty_d, s3_tx_q, s3_ty_q;

  logic signed [SW-1:0] adj_x, adj_y;
  logic signed [QW-1:0] qx, qy;
  logic in_x, in_y, src_in;
  logic [ADDR_W-1:0] fetch_addr;

  assign dim_max = EW'(MAX_DIM);
  assign w_eff   = (EW'(cfg_i.width) > dim_max) ? dim_max : EW'(cfg_i.width);
  assign h_eff   = (EW'(cfg_i.height) > dim_max) ? dim_max : EW'(cfg_i.height);
  assign ox      = w_eff >> 1;
  assign oy      = h_eff >> 1;

  assign pending = (QCNT_W+1)'(q_count_i) + (QCNT_W+1)'(s1_valid_q)
                 + (QCNT_W+1)'(s2_valid_q) + (QCNT_W+1)'(s3_valid_q);
  assign in_if.ready = pending < (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept = in_if.valid && in_if.ready;

  assign col_w     = EW'(in_if.col);
  assign row_w     = EW'(in_if.row);
  assign s1_dx_d   = $signed({1'b0, col_w}) - $signed({1'b0, ox});
  assign s1_dy_d   = $signed({1'b0, oy}) - $signed({1'b0, row_w});
  assign load_ok   = (col_w < dim_max) && (row_w < dim_max);
  assign load_addr = ADDR_W'(row_w) * ADDR_W'(MAX_DIM) + ADDR_W'(col_w);

  assign cdx_d = PW'($signed(cfg_i.cos_term)) * PW'(s1_dx_q);
  assign sdy_d = PW'($signed(cfg_i.sin_term)) * PW'(s1_dy_q);
  assign sdx_d = PW'($signed(cfg_i.sin_term)) * PW'(s1_dx_q);
  assign cdy_d = PW'($signed(cfg_i.cos_term)) * PW'(s1_dy_q);

  assign tx_d = SW'(s2_cdx_q) - SW'(s2_sdy_q) + SW'({ox, {FRAC_W{1'b0}}}) + SW'(HALF_Q);
  assign ty_d = SW'({oy, {FRAC_W{1'b0}}}) - SW'(s2_sdx_q) - SW'(s2_cdy_q) + SW'(HALF_Q);

  // truncate toward zero
  assign adj_x = s3_tx_q + (s3_tx_q[SW-1] ? SW'(TRUNC_BIAS) : SW'(0));
  assign adj_y = s3_ty_q + (s3_ty_q[SW-1] ? SW'(TRUNC_BIAS) : SW'(0));
  assign qx    = adj_x[SW-1:FRAC_W];
  assign qy    = adj_y[SW-1:FRAC_W];
  assign in_x  = !qx[QW-1] && ($unsigned(qx) < QW'(w_eff));
  assign in_y  = !qy[QW-1] && ($unsigned(qy) < QW'(h_eff));
  assign src_in = s3_fetch_q && in_x && in_y;
  assign fetch_addr = ADDR_W'($unsigned(qy)) * ADDR_W'(MAX_DIM) + ADDR_W'($unsigned(qx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_fetch_q <= (in_if.mode == MODE_FETCH);
    s1_wr_en_q <= (in_if.mode == MODE_LOAD) && load_ok;
    s1_addr_q  <= load_addr;
    s1_pixel_q <= in_if.pixel_in;
    s1_dx_q    <= s1_dx_d;
    s1_dy_q    <= s1_dy_d;

    s2_fetch_q <= s1_fetch_q;
    s2_wr_en_q <= s1_wr_en_q;
    s2_addr_q  <= s1_addr_q;
    s2_pixel_q <= s1_pixel_q;
    s2_cdx_q   <= cdx_d;
    s2_sdy_q   <= sdy_d;
    s2_sdx_q   <= sdx_d;
    s2_cdy_q   <= cdy_d;

    s3_fetch_q <= s2_fetch_q;
    s3_wr_en_q <= s2_wr_en_q;
    s3_addr_q  <= s2_addr_q;
    s3_pixel_q <= s2_pixel_q;
    s3_tx_q    <= tx_d;
    s3_ty_q    <= ty_d;
  end

  assign push_o             = s3_valid_q;
  assign push_ctrl_o.fetch  = s3_fetch_q;
  assign push_ctrl_o.wr_en  = s3_wr_en_q && !s3_fetch_q;
  assign push_ctrl_o.in_img = src_in;
  assign push_addr_o  = s3_fetch_q ? (src_in ? fetch_addr : '0) : s3_addr_q;
  assign push_pixel_o = s3_pixel_q;

endmodule

@@ rtl/irn_queue.sv @@
module irn_queue #(
  parameter int unsigned DATA_W = 49
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [DATA_W-1:0]          push_data_i,
  input  logic                       pop_i,
  output logic [DATA_W-1:0]          pop_data_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [irn_pkg::QCNT_W-1:0] count_o
);
  import irn_pkg::*;

  logic [DATA_W-1:0] entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic do_push, do_pop;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign count_o    = count_q;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/irn_back.sv @@
module irn_back #(
  parameter int unsigned STORE_DEPTH = 16384,
  parameter int unsigned ADDR_W      = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  irn_pkg::op_ctrl_t           ctrl_i,
  input  logic [ADDR_W-1:0]           addr_i,
  input  logic [irn_pkg::PIXEL_W-1:0] pixel_i,
  output logic                        pop_o,
  irn_out_if.source                   out_if
);
  import irn_pkg::*;

  logic [PIXEL_W-1:0] store_q [STORE_DEPTH];
  logic [PIXEL_W-1:0] rdata_q;
  logic out_valid_q, inside_q;
  logic fetch_pop;

  assign pop_o     = !q_empty_i && (!ctrl_i.fetch || !out_valid_q || out_if.ready);
  assign fetch_pop = pop_o && ctrl_i.fetch;

  always_ff @(posedge clk_i) begin
    if (pop_o && ctrl_i.wr_en) begin
      store_q[addr_i] <= pixel_i;
    end
    if (fetch_pop) begin
      rdata_q  <= store_q[addr_i];
      inside_q <= ctrl_i.in_img;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fetch_pop) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.inside_res = inside_q;
  assign out_if.pixel_out  = inside_q ? rdata_q : '0;

endmodule

@@ rtl/image_rotate_nearest_core.sv @@
// Nearest-neighbor rotation of a 32-bit pixel frame held in a MAX_DIM x MAX_DIM pixel store.
// A load beat (mode 0) writes pixel_in at (col,row); a fetch beat (mode 1) returns
// the source pixel found by rotating (col,row) about the image center with the Q2.14
// cos/sin terms, or zero with inside_res low when the source falls outside the
// image. Loads give no result. One beat is accepted per cycle while the output takes
// results, limited by the single store access each beat makes; a fetch result passes
// through the front stages, the queue entry and the registered store read, in that order,
// before it is offered, and the input stalls once the queue and the front stages together
// hold eight beats. The user must write registers only while the block is idle; the block
// does not enforce this. Store entries read before being loaded return undefined data.
`include "assert_macros.svh"

module image_rotate_nearest_core #(
  parameter int unsigned MAX_DIM = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [irn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [irn_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  irn_in_if.sink                         in_i,
  irn_out_if.source                      out_o
);
  import irn_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CTRL_W      = $bits(op_ctrl_t);
  localparam int unsigned ENTRY_W     = CTRL_W + ADDR_W + PIXEL_W;

  rot_cfg_t cfg_q;

  logic               push, pop, q_empty, q_full;
  logic [QCNT_W-1:0]  q_count;
  op_ctrl_t           push_ctrl, pop_ctrl;
  logic [ADDR_W-1:0]  push_addr, pop_addr;
  logic [PIXEL_W-1:0] push_pixel, pop_pixel;
  logic [ENTRY_W-1:0] pop_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width    <= DIM_W'(128);
      cfg_q.height   <= DIM_W'(128);
      cfg_q.cos_term <= TERM_W'(16384);
      cfg_q.sin_term <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:  cfg_q.width    <= cfg_wdata_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_q.height   <= cfg_wdata_i[DIM_W-1:0];
        REG_COS_TERM:     cfg_q.cos_term <= cfg_wdata_i[TERM_W-1:0];
        REG_SIN_TERM:     cfg_q.sin_term <= cfg_wdata_i[TERM_W-1:0];
        default: ;
      endcase
    end
  end

  irn_front #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_i),
    .cfg_i        (cfg_q),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_ctrl_o  (push_ctrl),
    .push_addr_o  (push_addr),
    .push_pixel_o (push_pixel)
  );

  irn_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_ctrl, push_addr, push_pixel}),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .empty_o     (q_empty),
    .full_o      (q_full),
    .count_o     (q_count)
  );

  assign pop_ctrl  = op_ctrl_t'(pop_entry[ENTRY_W-1 -: CTRL_W]);
  assign pop_addr  = pop_entry[PIXEL_W +: ADDR_W];
  assign pop_pixel = pop_entry[PIXEL_W-1:0];

  irn_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .ctrl_i    (pop_ctrl),
    .addr_i    (pop_addr),
    .pixel_i   (pop_pixel),
    .pop_o     (pop),
    .out_if    (out_o)
  );

  `IRN_ASSERT_NEVER(a_queue_overflow, clk_i, rst_ni, push && q_full && !pop)
  `IRN_ASSERT_NEVER(a_accept_credit, clk_i, rst_ni, in_i.valid && in_i.ready && q_full)
  `IRN_ASSERT(a_fetch_result, clk_i, rst_ni, pop && pop_ctrl.fetch |=> out_o.valid)
  `IRN_ASSERT(a_outside_zero, clk_i, rst_ni, out_o.valid && !out_o.inside_res |-> out_o.pixel_out == '0)

endmodule
